FILE: src/fpsc_pkg.sv
// shared constants and types for the flywheel pidf speed control unit
package fpsc_pkg;

  // flywheel to motor gear ratio, motor speed = flywheel speed / ratio
  localparam int GEAR_RATIO = 7;

  // reciprocal for the ratio divide; exact for 17-bit dividends and ratios up to 64
  localparam int RECIP_SHIFT = 23;
  localparam logic [23:0] RECIP_MULT =
    24'((2 ** RECIP_SHIFT + GEAR_RATIO - 1) / GEAR_RATIO);

  // drive voltage limit in millivolts
  localparam logic signed [14:0] VMAX = 15'sd12000;

  // rounding offset for the 2^-12 mV accumulator
  localparam logic signed [51:0] ROUND_HALF = 52'sd2048;

  localparam int FRAC_BITS = 12;

  typedef enum logic [2:0] {
    CFG_GAIN_P    = 3'd0,
    CFG_GAIN_I    = 3'd1,
    CFG_GAIN_D    = 3'd2,
    CFG_STATIC_FF = 3'd3,
    CFG_GAIN_V    = 3'd4,
    CFG_COAST     = 3'd5
  } cfg_index_t;

  typedef logic signed [15:0] speed_err_t;

endpackage

FILE: src/fpsc_speed_error.sv
// speed error at the motor: target scaled by the gear ratio minus measured, saturated
module fpsc_speed_error (
  input  logic [12:0]               target_speed,
  input  logic signed [14:0]        measured_velocity,
  output fpsc_pkg::speed_err_t      speed_error
);

  logic [36:0]        prod;
  logic [16:0]        quot;
  logic signed [18:0] diff;

  always_comb begin
    // floor(target * 16 / ratio) via multiply by reciprocal
    prod = 37'(target_speed) * 37'(fpsc_pkg::RECIP_MULT);
    quot = 17'(prod >> (fpsc_pkg::RECIP_SHIFT - 4));
    diff = $signed({2'b00, quot}) - 19'(measured_velocity);
    if (diff > 19'sd32767) begin
      speed_error = 16'sh7fff;
    end else if (diff < -19'sd32768) begin
      speed_error = 16'sh8000;
    end else begin
      speed_error = 16'(diff);
    end
  end

endmodule

FILE: src/flywheel_pidf_speed_control_unit.sv
// flywheel pidf speed control unit, top level
// Takes one control tick per clock cycle while the output is not stalled and returns one drive
// command per tick in order. The pipeline is input register, gear-ratio divide and error clamp,
// integral and derivative update, gain multiplies, accumulate, then round and clamp into the
// output register. A stall on the output side holds every stage. Configuration writes are
// taken at any time and are meant to be done while no tick is in flight.
module flywheel_pidf_speed_control_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [12:0] target_speed, [27:13] measured_velocity, rest zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [14:0] drive_voltage, [15] zero
  output logic        m_tuser,   // [0] saturated
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // configuration
  logic signed [15:0] gain_p, gain_i, gain_d, gain_v;
  logic signed [14:0] static_ff;
  logic               coast_on_zero;

  // controller state
  logic signed [31:0] integral_sum;
  fpsc_pkg::speed_err_t previous_error;
  logic signed [1:0]  error_sign;

  // pipeline
  logic               en;
  logic               v1, v2, v3, v4, v5;
  logic [12:0]        s1_target;
  logic signed [14:0] s1_meas;
  fpsc_pkg::speed_err_t s2_err;
  logic signed [14:0] s2_meas;
  logic               s2_tzero;
  fpsc_pkg::speed_err_t s3_err;
  logic signed [31:0] s3_integral;
  logic signed [16:0] s3_deriv;
  logic signed [14:0] s3_meas;
  logic signed [1:0]  s3_sign;
  logic               s3_tzero;
  logic signed [31:0] s4_p;
  logic signed [47:0] s4_i;
  logic signed [32:0] s4_d;
  logic signed [30:0] s4_v;
  logic signed [15:0] s4_stat;
  logic               s4_tzero;
  logic signed [50:0] s5_acc;
  logic               s5_tzero;

  fpsc_pkg::speed_err_t err_next;
  logic signed [32:0] sum_wide;
  logic signed [31:0] integral_next;
  logic signed [1:0]  sign_next;
  logic signed [51:0] neg;
  logic signed [39:0] cmd;
  logic               sat_next;
  logic signed [14:0] drive_next;
  logic signed [14:0] drive;

  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en;
  assign cfg_ready = 1'b1;
  assign m_tdata   = {1'b0, drive};

  fpsc_speed_error u_err (
    .target_speed      (s1_target),
    .measured_velocity (s1_meas),
    .speed_error       (err_next)
  );

  // integral and sign for the item in stage two
  always_comb begin
    sum_wide = 33'(integral_sum) + 33'(s2_err);
    if (sum_wide > 33'sh0_7fff_ffff) begin
      integral_next = 32'sh7fff_ffff;
    end else if (sum_wide < -33'sh0_8000_0000) begin
      integral_next = 32'sh8000_0000;
    end else begin
      integral_next = 32'(sum_wide);
    end
    if (s2_err > 16'sd0) begin
      sign_next = 2'sd1;
    end else if (s2_err < 16'sd0) begin
      sign_next = -2'sd1;
    end else begin
      sign_next = 2'sd0;
    end
  end

  // negate and round to nearest mV, ties up, then clamp, or coast to zero on a zero target
  always_comb begin
    neg = fpsc_pkg::ROUND_HALF - 52'(s5_acc);
    cmd = 40'(neg >>> fpsc_pkg::FRAC_BITS);
    if (s5_tzero && coast_on_zero) begin
      sat_next   = 1'b0;
      drive_next = 15'sd0;
    end else if (cmd > 40'(fpsc_pkg::VMAX)) begin
      sat_next   = 1'b1;
      drive_next = fpsc_pkg::VMAX;
    end else if (cmd < -40'(fpsc_pkg::VMAX)) begin
      sat_next   = 1'b1;
      drive_next = -fpsc_pkg::VMAX;
    end else begin
      sat_next   = 1'b0;
      drive_next = 15'(cmd);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p        <= '0;
      gain_i        <= '0;
      gain_d        <= '0;
      gain_v        <= '0;
      static_ff     <= '0;
      coast_on_zero <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (fpsc_pkg::cfg_index_t'(cfg_index))
        fpsc_pkg::CFG_GAIN_P:    gain_p        <= cfg_data;
        fpsc_pkg::CFG_GAIN_I:    gain_i        <= cfg_data;
        fpsc_pkg::CFG_GAIN_D:    gain_d        <= cfg_data;
        fpsc_pkg::CFG_STATIC_FF: static_ff     <= cfg_data[14:0];
        fpsc_pkg::CFG_GAIN_V:    gain_v        <= cfg_data;
        fpsc_pkg::CFG_COAST:     coast_on_zero <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // control: valids and controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      v1             <= 1'b0;
      v2             <= 1'b0;
      v3             <= 1'b0;
      v4             <= 1'b0;
      v5             <= 1'b0;
      m_tvalid       <= 1'b0;
      integral_sum   <= '0;
      previous_error <= '0;
      error_sign     <= '0;
    end else if (en) begin
      v1       <= s_tvalid;
      v2       <= v1;
      v3       <= v2;
      v4       <= v3;
      v5       <= v4;
      m_tvalid <= v5;
      if (v2) begin
        // integral clears once the output has used it, on a change of error sign
        integral_sum   <= (sign_next != error_sign) ? 32'sd0 : integral_next;
        error_sign     <= sign_next;
        previous_error <= s2_err;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      s1_target   <= s_tdata[12:0];
      s1_meas     <= s_tdata[27:13];

      s2_err      <= err_next;
      s2_meas     <= s1_meas;
      s2_tzero    <= (s1_target == 13'd0);

      s3_err      <= s2_err;
      s3_integral <= integral_next;
      s3_deriv    <= 17'(s2_err) - 17'(previous_error);
      s3_meas     <= s2_meas;
      s3_sign     <= sign_next;
      s3_tzero    <= s2_tzero;

      s4_p        <= 32'(gain_p) * 32'(s3_err);
      s4_i        <= 48'(gain_i) * 48'(s3_integral);
      s4_d        <= 33'(gain_d) * 33'(s3_deriv);
      s4_v        <= 31'(gain_v) * 31'(s3_meas);
      s4_stat     <= (s3_sign > 2'sd0) ? 16'(static_ff) :
                     (s3_sign < 2'sd0) ? -16'(static_ff) : 16'sd0;
      s4_tzero    <= s3_tzero;

      s5_acc      <= 51'(s4_p) + 51'(s4_i) + 51'(s4_d) + 51'(s4_v)
                     + (51'(s4_stat) <<< fpsc_pkg::FRAC_BITS);
      s5_tzero    <= s4_tzero;

      drive       <= drive_next;
      m_tuser     <= sat_next;
    end
  end

  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (drive <= fpsc_pkg::VMAX) && (drive >= -fpsc_pkg::VMAX))
    else $error("drive voltage outside limit");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (drive == fpsc_pkg::VMAX) || (drive == -fpsc_pkg::VMAX))
    else $error("saturated flag without clamped drive");

  a_sign_code: assert property (@(posedge clk) disable iff (rst)
    error_sign != -2'sd2)
    else $error("invalid error sign code");

  a_integral_clear: assert property (@(posedge clk) disable iff (rst)
    en && v2 && (sign_next != error_sign) |=> integral_sum == 32'sd0)
    else $error("integral not cleared on sign change");

endmodule
